/* sv/san_pkg.sv */
// Package for the symmetric adjacency normalizer.
// Holds payload structs, controller/datapath command and status types, constants.
// No dependencies.
package san_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam logic [10:0] NODE_COUNT_RST = 11'd1024;
    localparam int ROOT_W = 23;
    localparam int DIV_LAST_STEP = 44;
    localparam int SQRT_LAST_STEP = 22;

    localparam logic [1:0] ADDR_ROW = 2'd0;
    localparam logic [1:0] ADDR_COL = 2'd1;
    localparam logic [1:0] ADDR_CNT = 2'd2;

    localparam logic [1:0] WR_ZERO = 2'd0;
    localparam logic [1:0] WR_ACC  = 2'd1;
    localparam logic [1:0] WR_ROOT = 2'd2;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_EMIT  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [9:0]  row_node;
        logic [9:0]  col_node;
        logic [15:0] edge_weight;
        logic        last_edge;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  out_row;
        logic [9:0]  out_col;
        logic [15:0] norm_weight;
        logic        saturated;
        logic        out_last;
    } out_item_t;

    typedef struct packed {
        logic       item_load;
        logic [1:0] addr_sel;
        logic       mem_we;
        logic [1:0] wr_sel;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       swept_set;
        logic       swept_clr;
        logic       div_init;
        logic       div_step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       cap_row;
        logic       cap_col;
        logic       mul_a;
        logic       mul_lo;
        logic       mul_hi;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic command;
        logic last_edge;
        logic row_ok;
        logic cnt_last;
        logic cnt_at_end;
        logic step_last;
        logic deg_zero;
        logic out_full;
    } sts_t;

endpackage

/* sv/san_datapath.sv */
// Datapath: degree store, item register, counters, divider, square root, multipliers.
// Depends on san_pkg.
module san_datapath #(
    parameter int MAX_NODES = san_pkg::MAX_NODES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  san_pkg::in_item_t  in_data,
    input  logic               cfg_wr,
    input  logic [10:0]        cfg_data,
    input  san_pkg::cmd_t      cmd,
    output san_pkg::sts_t      sts,
    output logic               out_valid,
    input  logic               out_stall,
    output san_pkg::out_item_t out_data
);
    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int ROOT_W_L = san_pkg::ROOT_W;

    logic [31:0] mem [MAX_NODES];
    logic [31:0] rd_data_reg;
    logic [AW-1:0] addr;
    logic [31:0] wdata;

    san_pkg::in_item_t item_reg;
    logic [10:0] node_count_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] swept_reg, swept_next;
    logic [CW-1:0] n_active;

    logic [31:0] dvs_reg;
    logic [31:0] rem_reg;
    logic [44:0] quo_reg;
    logic [5:0]  step_reg;
    logic [32:0] div_trial;
    logic [32:0] div_diff;
    logic        div_bit;

    logic [45:0] sq_reg;
    logic [25:0] srem_reg;
    logic [ROOT_W_L-1:0] root_reg;
    logic [25:0] sq_trial;
    logic [25:0] sq_cmp;

    logic [ROOT_W_L-1:0] root_row_reg, root_col_reg;
    logic [38:0] prod_reg;
    logic [42:0] plo_reg;
    logic [41:0] phi_reg;
    logic [62:0] total;
    logic [30:0] scaled;
    logic [32:0] acc_sum;

    san_pkg::out_item_t out_reg;
    logic out_valid_reg;

    always_comb
    begin
        unique case (cmd.addr_sel)
            san_pkg::ADDR_ROW: addr = AW'(item_reg.row_node);
            san_pkg::ADDR_COL: addr = AW'(item_reg.col_node);
            default:           addr = AW'(cnt_reg);
        endcase
    end

    assign acc_sum = {1'b0, rd_data_reg} + 33'(item_reg.edge_weight);

    always_comb
    begin
        unique case (cmd.wr_sel)
            san_pkg::WR_ACC:  wdata = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
            san_pkg::WR_ROOT: wdata = 32'(root_reg);
            default:          wdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[addr] <= wdata;
        end
        rd_data_reg <= mem[addr];
    end

    assign n_active = (32'(node_count_reg) < MAX_NODES) ? CW'(node_count_reg)
                                                         : CW'(MAX_NODES);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        swept_next = swept_reg;
        if (cmd.swept_clr)
        begin
            swept_next = '0;
        end
        else if (cmd.swept_set)
        begin
            swept_next = n_active;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            swept_reg      <= '0;
            node_count_reg <= san_pkg::NODE_COUNT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            swept_reg <= swept_next;
            if (cfg_wr)
            begin
                node_count_reg <= cfg_data;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // restoring divide 2^44 / d, one quotient bit per cycle
    assign div_bit   = (step_reg == 6'(san_pkg::DIV_LAST_STEP));
    assign div_trial = {rem_reg, div_bit};
    assign div_diff  = div_trial - {1'b0, dvs_reg};

    // digit-by-digit square root, one root bit per cycle
    assign sq_cmp   = {srem_reg[23:0], sq_reg[45:44]};
    assign sq_trial = {1'b0, root_reg, 2'b01};

    assign total  = 63'({phi_reg, 20'd0}) + 63'(plo_reg);
    assign scaled = total[62:32];

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= in_data;
        end
        if (cmd.div_init)
        begin
            dvs_reg  <= rd_data_reg;
            rem_reg  <= '0;
            quo_reg  <= '0;
            step_reg <= 6'(san_pkg::DIV_LAST_STEP);
        end
        else if (cmd.sqrt_init)
        begin
            sq_reg   <= {1'b0, quo_reg};
            srem_reg <= '0;
            root_reg <= '0;
            step_reg <= 6'(san_pkg::SQRT_LAST_STEP);
        end
        else if (cmd.div_step)
        begin
            if (!div_diff[32])
            begin
                rem_reg <= div_diff[31:0];
                quo_reg <= {quo_reg[43:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_trial[31:0];
                quo_reg <= {quo_reg[43:0], 1'b0};
            end
            step_reg <= step_reg - 6'd1;
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_cmp >= sq_trial)
            begin
                srem_reg <= sq_cmp - sq_trial;
                root_reg <= {root_reg[ROOT_W_L-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= sq_cmp;
                root_reg <= {root_reg[ROOT_W_L-2:0], 1'b0};
            end
            sq_reg   <= {sq_reg[43:0], 2'b00};
            step_reg <= step_reg - 6'd1;
        end
        if (cmd.cap_row)
        begin
            root_row_reg <= (32'(item_reg.row_node) < 32'(swept_reg))
                            ? rd_data_reg[ROOT_W_L-1:0] : '0;
        end
        if (cmd.cap_col)
        begin
            root_col_reg <= (32'(item_reg.col_node) < 32'(swept_reg))
                            ? rd_data_reg[ROOT_W_L-1:0] : '0;
        end
        if (cmd.mul_a)
        begin
            prod_reg <= 39'(item_reg.edge_weight) * 39'(root_row_reg);
        end
        if (cmd.mul_lo)
        begin
            plo_reg <= 43'(prod_reg[19:0]) * 43'(root_col_reg);
        end
        if (cmd.mul_hi)
        begin
            phi_reg <= 42'(prod_reg[38:20]) * 42'(root_col_reg);
        end
        if (cmd.out_load)
        begin
            out_reg.out_row     <= item_reg.row_node;
            out_reg.out_col     <= item_reg.col_node;
            out_reg.norm_weight <= (scaled > 31'hFFFF) ? 16'hFFFF : scaled[15:0];
            out_reg.saturated   <= (scaled > 31'hFFFF);
            out_reg.out_last    <= item_reg.last_edge;
        end
    end

    assign sts.command    = item_reg.command;
    assign sts.last_edge  = item_reg.last_edge;
    assign sts.row_ok     = (32'(item_reg.row_node) < MAX_NODES);
    assign sts.cnt_last   = (cnt_reg == CW'(MAX_NODES - 1));
    assign sts.cnt_at_end = (cnt_reg >= n_active);
    assign sts.step_last  = (step_reg == 6'd0);
    assign sts.deg_zero   = (rd_data_reg == 32'd0);
    assign sts.out_full   = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* sv/san_ctrl.sv */
// Controller state machine: sequences accumulate, conversion sweep, emit and clear.
// Depends on san_pkg.
module san_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  san_pkg::sts_t sts,
    output san_pkg::cmd_t cmd
);
    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DISP   = 5'd2;
    localparam logic [4:0] S_ACC_WR = 5'd3;
    localparam logic [4:0] S_CV_CHK = 5'd4;
    localparam logic [4:0] S_CV_RD  = 5'd5;
    localparam logic [4:0] S_DIV    = 5'd6;
    localparam logic [4:0] S_SQI    = 5'd7;
    localparam logic [4:0] S_SQRT   = 5'd8;
    localparam logic [4:0] S_CV_WR  = 5'd9;
    localparam logic [4:0] S_EM_ROW = 5'd10;
    localparam logic [4:0] S_EM_COL = 5'd11;
    localparam logic [4:0] S_MUL_A  = 5'd12;
    localparam logic [4:0] S_MUL_LO = 5'd13;
    localparam logic [4:0] S_MUL_HI = 5'd14;
    localparam logic [4:0] S_OUT    = 5'd15;

    logic [4:0] state_reg, state_next;
    logic conv_reg, conv_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        conv_next  = conv_reg;
        cmd        = '0;
        cmd.addr_sel = san_pkg::ADDR_CNT;
        cmd.wr_sel   = san_pkg::WR_ZERO;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.mem_we  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.addr_sel = san_pkg::ADDR_ROW;
                if (sts.command == san_pkg::CMD_ACCUM)
                begin
                    state_next = conv_reg ? S_IDLE : S_ACC_WR;
                end
                else
                begin
                    state_next = conv_reg ? S_EM_ROW : S_IDLE;
                end
            end
            S_ACC_WR:
            begin
                cmd.addr_sel = san_pkg::ADDR_ROW;
                cmd.wr_sel   = san_pkg::WR_ACC;
                cmd.mem_we   = sts.row_ok;
                if (sts.last_edge)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_CV_CHK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CV_CHK:
            begin
                if (sts.cnt_at_end)
                begin
                    cmd.swept_set = 1'b1;
                    conv_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_CV_RD;
                end
            end
            S_CV_RD:
            begin
                if (sts.deg_zero)
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_CV_CHK;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = S_SQI;
                end
            end
            S_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.step_last)
                begin
                    state_next = S_CV_WR;
                end
            end
            S_CV_WR:
            begin
                cmd.wr_sel  = san_pkg::WR_ROOT;
                cmd.mem_we  = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = S_CV_CHK;
            end
            S_EM_ROW:
            begin
                cmd.cap_row  = 1'b1;
                cmd.addr_sel = san_pkg::ADDR_COL;
                state_next   = S_EM_COL;
            end
            S_EM_COL:
            begin
                cmd.addr_sel = san_pkg::ADDR_COL;
                cmd.cap_col  = 1'b1;
                state_next   = S_MUL_A;
            end
            S_MUL_A:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.last_edge)
                    begin
                        cmd.cnt_clr   = 1'b1;
                        cmd.swept_clr = 1'b1;
                        conv_next     = 1'b0;
                        state_next    = S_CLR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            conv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            conv_reg  <= conv_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_full)
        else $error("result loaded over a pending transfer");
    a_acc_unconverted: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_we && cmd.wr_sel == san_pkg::WR_ACC) |-> !conv_reg)
        else $error("degree update after conversion");
    a_conv_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(conv_reg) |-> $past(state_reg == S_CV_CHK))
        else $error("converted flag set outside sweep end");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(conv_reg) |-> state_reg == S_CLR)
        else $error("store not cleared after final emit");
`endif

endmodule

/* sv/sym_adjacency_normalizer_top.sv */
// Top level of the symmetric adjacency normalizer (D^-1/2 A D^-1/2).
// Depends on san_pkg, san_ctrl, san_datapath.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data  (san_pkg::in_item_t)
//  out     | output    | out_valid/out_stall| out_data (san_pkg::out_item_t)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_data (node_count, 11 bits)
//
// Emit edges wait in S_OUT while the output stalls.
// Inverse-root sweep after pass one: per node, unless its degree is zero, the
// one-bit-per-cycle divider (45 steps) and square root (23 steps) run in turn.
// After reset and after pass two's last edge, a clear pass writes zeros to all
// MAX_NODES entries of the degree store; input is stalled meanwhile.
// A waiting result holds its register; the next edge is accepted meanwhile.
module sym_adjacency_normalizer_top #(
    parameter int MAX_NODES = san_pkg::MAX_NODES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  san_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output san_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [10:0]        cfg_data
);
    san_pkg::cmd_t cmd;
    san_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    san_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    san_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* tb/san_checker.sv */
// Checker for the symmetric adjacency normalizer: watches the in, out and cfg channels,
// predicts normalized edges from its own degree store and compares them field by field.
// Depends on san_pkg.
module san_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  san_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  san_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [10:0]        cfg_data,
    output int                 pending,
    output int                 errors
);

    localparam int STORE_DEPTH = 1024;

    logic [31:0]        degree_mem [STORE_DEPTH];
    logic               roots_ready;
    int unsigned        roots_span;
    logic [10:0]        node_count;
    san_pkg::out_item_t norm_q [$];

    assign pending = norm_q.size();

    function automatic logic [31:0] inv_root(logic [31:0] d);
        logic [63:0] t;
        logic [31:0] r;
        r = '0;
        for (int b = 22; b >= 0; b--) begin
            t = {32'd0, r | (32'd1 << b)};
            if (t * t * {32'd0, d} <= (64'd1 << 44))
                r = t[31:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] root_at(logic [9:0] idx);
        if (idx >= roots_span)
            return '0;
        return {32'd0, degree_mem[idx]};
    endfunction

    task automatic predict_edge(san_pkg::in_item_t it);
        logic [32:0]        sum;
        logic [63:0]        prod;
        int unsigned        span;
        san_pkg::out_item_t e;
        if (it.command == san_pkg::CMD_ACCUM) begin
            if (roots_ready)
                return;
            sum = {1'b0, degree_mem[it.row_node]} + {17'd0, it.edge_weight};
            degree_mem[it.row_node] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (it.last_edge) begin
                span = (node_count < STORE_DEPTH) ? node_count : STORE_DEPTH;
                for (int i = 0; i < span; i++)
                    if (degree_mem[i] != 0)
                        degree_mem[i] = inv_root(degree_mem[i]);
                roots_span  = span;
                roots_ready = 1'b1;
            end
            return;
        end
        if (!roots_ready)
            return;
        prod = ({48'd0, it.edge_weight} * root_at(it.row_node) * root_at(it.col_node)) >> 32;
        e.out_row     = it.row_node;
        e.out_col     = it.col_node;
        e.saturated   = prod > 64'hFFFF;
        e.norm_weight = e.saturated ? 16'hFFFF : prod[15:0];
        e.out_last    = it.last_edge;
        norm_q = {norm_q, e};
        if (it.last_edge) begin
            for (int i = 0; i < STORE_DEPTH; i++)
                degree_mem[i] = '0;
            roots_ready = 1'b0;
            roots_span  = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        san_pkg::out_item_t exp_item;
        if (!rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++)
                degree_mem[i] = '0;
            roots_ready = 1'b0;
            roots_span  = 0;
            node_count  = san_pkg::NODE_COUNT_RST;
            norm_q.delete();
            errors = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (norm_q.size() == 0) begin
                    $display("%0t: unexpected transfer %h", $time, out_data);
                    errors++;
                end else begin
                    exp_item = norm_q.pop_front();
                    if (exp_item.out_row !== out_data.out_row) begin
                        $display("%0t: out_row exp %0d got %0d", $time,
                                 exp_item.out_row, out_data.out_row);
                        errors++;
                    end
                    if (exp_item.out_col !== out_data.out_col) begin
                        $display("%0t: out_col exp %0d got %0d", $time,
                                 exp_item.out_col, out_data.out_col);
                        errors++;
                    end
                    if (exp_item.norm_weight !== out_data.norm_weight) begin
                        $display("%0t: norm_weight exp %h got %h", $time,
                                 exp_item.norm_weight, out_data.norm_weight);
                        errors++;
                    end
                    if (exp_item.saturated !== out_data.saturated) begin
                        $display("%0t: saturated exp %b got %b", $time,
                                 exp_item.saturated, out_data.saturated);
                        errors++;
                    end
                    if (exp_item.out_last !== out_data.out_last) begin
                        $display("%0t: out_last exp %b got %b", $time,
                                 exp_item.out_last, out_data.out_last);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                node_count = cfg_data;
            if (in_valid && !in_stall)
                predict_edge(in_data);
        end
    end

endmodule

/* tb/tb_sym_adjacency_normalizer_top.sv */
// Testbench top for sym_adjacency_normalizer_top: streams edge lists twice per graph
// under random gaps and output stalls, with node_count changes between graphs.
// Depends on san_pkg, sym_adjacency_normalizer_top and san_checker.
module tb_sym_adjacency_normalizer_top;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    san_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_stall;
    san_pkg::out_item_t out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [10:0]        cfg_data;
    int                 pending;
    int                 errors;
    int                 stall_left;
    bit                 burst;

    sym_adjacency_normalizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    san_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // receiver: random stall per transfer, with stall-free bursts
    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            if ($urandom_range(0, 63) == 0)
                burst = ~burst;
            stall_left = burst ? 0 : $urandom_range(0, 15);
        end else if (stall_left != 0) begin
            stall_left--;
        end
        out_stall <= (stall_left != 0);
    end

    task automatic send_edge(logic cmd, logic [9:0] row, logic [9:0] col,
                             logic [15:0] w, logic last);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{command: cmd, row_node: row, col_node: col,
                      edge_weight: w, last_edge: last};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic set_node_count(logic [10:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || in_stall) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [9:0] pick_node(int n);
        if ($urandom_range(0, 9) == 0 || n <= 0)
            return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, (n + 3 > 1023) ? 1023 : n + 3));
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 8192));
        endcase
    endfunction

    task automatic run_graph(int n, int edges);
        logic [9:0] rows [30];
        logic [9:0] cols [30];
        for (int i = 0; i < edges; i++) begin
            rows[i] = pick_node(n);
            cols[i] = pick_node(n);
        end
        if ($urandom_range(0, 3) == 0)
            send_edge(san_pkg::CMD_EMIT, pick_node(n), pick_node(n), pick_weight(),
                      1'($urandom_range(0, 1)));
        for (int i = 0; i < edges; i++)
            send_edge(san_pkg::CMD_ACCUM, rows[i], cols[i], pick_weight(), i == edges - 1);
        if ($urandom_range(0, 3) == 0)
            send_edge(san_pkg::CMD_ACCUM, pick_node(n), pick_node(n), pick_weight(),
                      1'($urandom_range(0, 1)));
        for (int i = 0; i < edges; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_edge(san_pkg::CMD_EMIT, pick_node(n), pick_node(n),
                          16'($urandom_range(0, 65535)), 1'b0);
            else
                send_edge(san_pkg::CMD_EMIT, rows[i], cols[i],
                          16'($urandom_range(0, 65535)), 1'b0);
        end
        send_edge(san_pkg::CMD_EMIT, rows[0], cols[0], pick_weight(), 1'b1);
    endtask

    initial begin
        int sent;
        int n;
        int e;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        out_stall  = 1'b0;
        stall_left = 0;
        burst      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: emit before conversion, single node, saturation, max indices
        set_node_count(11'd1);
        send_edge(san_pkg::CMD_EMIT, 10'd0, 10'd0, 16'hFFFF, 1'b1);
        send_edge(san_pkg::CMD_ACCUM, 10'd0, 10'd1023, 16'd1, 1'b0);
        send_edge(san_pkg::CMD_ACCUM, 10'd1023, 10'd0, 16'hFFFF, 1'b1);
        send_edge(san_pkg::CMD_ACCUM, 10'd0, 10'd0, 16'hFFFF, 1'b1);
        send_edge(san_pkg::CMD_EMIT, 10'd0, 10'd0, 16'hFFFF, 1'b0);
        send_edge(san_pkg::CMD_EMIT, 10'd0, 10'd0, 16'h0000, 1'b0);
        send_edge(san_pkg::CMD_EMIT, 10'd0, 10'd0, 16'h1000, 1'b0);
        send_edge(san_pkg::CMD_EMIT, 10'd1023, 10'd1023, 16'hFFFF, 1'b1);
        set_node_count(11'd0);
        send_edge(san_pkg::CMD_ACCUM, 10'd5, 10'd5, 16'h1000, 1'b1);
        send_edge(san_pkg::CMD_EMIT, 10'd5, 10'd5, 16'h1000, 1'b1);
        set_node_count(11'd2047);
        send_edge(san_pkg::CMD_ACCUM, 10'd1023, 10'd3, 16'h5555, 1'b0);
        send_edge(san_pkg::CMD_ACCUM, 10'd3, 10'd1023, 16'hAAAA, 1'b1);
        send_edge(san_pkg::CMD_EMIT, 10'd1023, 10'd3, 16'hFFFF, 1'b0);
        send_edge(san_pkg::CMD_EMIT, 10'd3, 10'd1023, 16'h8000, 1'b0);
        send_edge(san_pkg::CMD_EMIT, 10'd2, 10'd3, 16'h7FFF, 1'b1);

        sent = 0;
        while (sent < 1300) begin
            case ($urandom_range(0, 19))
                0:       n = 1024;
                1:       n = 0;
                2:       n = 1;
                default: n = $urandom_range(2, 48);
            endcase
            e = $urandom_range(1, 30);
            set_node_count(n == 1024 && $urandom_range(0, 1) ? 11'd2047 : n[10:0]);
            run_graph(n, e);
            sent += 2 * e;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("tb_sym_adjacency_normalizer_top passed");
        else
            $display("tb_sym_adjacency_normalizer_top failed");
        $finish;
    end

    initial begin
        #60000000;
        $display("tb_sym_adjacency_normalizer_top failed");
        $finish;
    end

endmodule

/* files.f */
sv/san_pkg.sv
sv/san_datapath.sv
sv/san_ctrl.sv
sv/sym_adjacency_normalizer_top.sv
tb/san_checker.sv
tb/tb_sym_adjacency_normalizer_top.sv
